// ===== design/xucr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64 unwind code replay package
// Item and result types, mode, kind, error and unwind op codes.
// ----------------------------------------------------------------------------
package xucr_pkg;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_SLOT   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_RESTORE = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_BAD_INFO  = 2'd2,
    ERR_BAD_OP    = 2'd3
  } err_t;

  // Unwind operation codes that the replay understands.
  localparam logic [3:0] OP_PUSH_NONVOL = 4'd0;
  localparam logic [3:0] OP_ALLOC_LARGE = 4'd1;
  localparam logic [3:0] OP_ALLOC_SMALL = 4'd2;
  localparam logic [3:0] OP_SET_FPREG   = 4'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] slot_value;
    logic [63:0] stack_pointer;
    logic [3:0]  frame_register;
    logic [63:0] frame_register_value;
    logic [3:0]  frame_offset;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  register_number;
    logic [63:0] address;
    logic [63:0] caller_stack_pointer;
    logic [63:0] establisher_frame;
    logic [1:0]  error_code;
  } result_t;

endpackage : xucr_pkg
`default_nettype wire

// ===== design/x64_unwind_code_replay_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64 unwind code replay
// Walks one frame's unwind codes and reports register restores and the
// caller frame.
// ----------------------------------------------------------------------------
// A begin item sets the frame base, either from the frame register value less
// sixteen times the frame offset or, with no frame register, from the stack
// pointer. Each slot item then replays one 16-bit unwind code against the
// running walk pointer: a push gives a restore result with the register and
// its stack address, allocations advance the pointer, and large allocations
// consume one or two extension slots. A finish item gives the return-address
// location, the caller stack pointer and the establisher frame. Each item
// gives at most one result. After an error only one error result is given and
// slot and finish items are dropped until the next begin. The block takes one
// item per cycle while its input stage is not held: an item is registered in
// the input register at its transfer, then decoded and applied to the walk
// state, and its result is registered in the output register. The input
// stage holds only while a result is pending in the output register and
// the next staged item also has one to give.
module x64_unwind_code_replay_top
  import xucr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  // Input register.
  logic  stage_valid;
  item_t stage;

  // Walk state.
  logic [63:0] walk_pointer;
  logic [63:0] frame_base;
  logic [1:0]  pending_slots;
  logic        large_unscaled;
  logic [15:0] size_low_half;
  logic        error_seen;

  logic [63:0] walk_pointer_next;
  logic [63:0] frame_base_next;
  logic [1:0]  pending_slots_next;
  logic        large_unscaled_next;
  logic [15:0] size_low_half_next;
  logic        error_seen_next;

  result_t result_next;
  logic    emit;
  logic    advance;

  // Decode of the staged item and the state it leaves behind.
  always_comb begin
    logic [3:0] op;
    logic [3:0] info;
    op   = stage.slot_value[11:8];
    info = stage.slot_value[15:12];

    walk_pointer_next   = walk_pointer;
    frame_base_next     = frame_base;
    pending_slots_next  = pending_slots;
    large_unscaled_next = large_unscaled;
    size_low_half_next  = size_low_half;
    error_seen_next     = error_seen;
    emit                = 1'b0;
    result_next         = '0;

    if (stage.mode == MODE_BEGIN) begin
      if (stage.frame_register != 4'd0) begin
        frame_base_next = stage.frame_register_value - {56'd0, stage.frame_offset, 4'd0};
      end else begin
        frame_base_next = stage.stack_pointer;
      end
      walk_pointer_next   = frame_base_next;
      pending_slots_next  = 2'd0;
      large_unscaled_next = 1'b0;
      size_low_half_next  = 16'd0;
      error_seen_next     = 1'b0;
    end else if (stage.mode == MODE_NONE || error_seen) begin
      // Dropped with no result.
    end else if (stage.mode == MODE_FINISH) begin
      emit = 1'b1;
      if (pending_slots != 2'd0) begin
        error_seen_next        = 1'b1;
        pending_slots_next     = 2'd0;
        result_next.kind       = KIND_ERROR;
        result_next.error_code = ERR_TRUNCATED;
      end else begin
        result_next.kind                 = KIND_DONE;
        result_next.address              = walk_pointer;
        result_next.caller_stack_pointer = walk_pointer + 64'd8;
        result_next.establisher_frame    = frame_base;
      end
    end else if (pending_slots != 2'd0) begin
      // Extension slot of a large allocation.
      if (!large_unscaled) begin
        walk_pointer_next  = walk_pointer + {45'd0, stage.slot_value, 3'd0};
        pending_slots_next = 2'd0;
      end else if (pending_slots[1]) begin
        size_low_half_next = stage.slot_value;
        pending_slots_next = 2'd1;
      end else begin
        walk_pointer_next  = walk_pointer + {32'd0, stage.slot_value, size_low_half};
        pending_slots_next = 2'd0;
      end
    end else begin
      case (op)
        OP_PUSH_NONVOL: begin
          emit                        = 1'b1;
          result_next.kind            = KIND_RESTORE;
          result_next.register_number = info;
          result_next.address         = walk_pointer;
          walk_pointer_next           = walk_pointer + 64'd8;
        end
        OP_ALLOC_LARGE: begin
          if (info == 4'd0) begin
            pending_slots_next  = 2'd1;
            large_unscaled_next = 1'b0;
          end else if (info == 4'd1) begin
            pending_slots_next  = 2'd2;
            large_unscaled_next = 1'b1;
          end else begin
            emit                   = 1'b1;
            error_seen_next        = 1'b1;
            pending_slots_next     = 2'd0;
            result_next.kind       = KIND_ERROR;
            result_next.error_code = ERR_BAD_INFO;
          end
        end
        OP_ALLOC_SMALL: begin
          // Size is (info + 1) * 8.
          walk_pointer_next = walk_pointer + {56'd0, {1'b0, info} + 5'd1, 3'd0};
        end
        OP_SET_FPREG: begin
          // No effect on the walk.
        end
        default: begin
          emit                   = 1'b1;
          error_seen_next        = 1'b1;
          pending_slots_next     = 2'd0;
          result_next.kind       = KIND_ERROR;
          result_next.error_code = ERR_BAD_OP;
        end
      endcase
    end
  end

  // The staged item moves on when its result, if any, has room.
  assign advance    = stage_valid && (!result_valid || result_ready || !emit);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
    if (item_ready) begin
      stage <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_pointer   <= 64'd0;
      frame_base     <= 64'd0;
      pending_slots  <= 2'd0;
      large_unscaled <= 1'b0;
      size_low_half  <= 16'd0;
      error_seen     <= 1'b0;
    end else if (advance) begin
      walk_pointer   <= walk_pointer_next;
      frame_base     <= frame_base_next;
      pending_slots  <= pending_slots_next;
      large_unscaled <= large_unscaled_next;
      size_low_half  <= size_low_half_next;
      error_seen     <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance && emit) begin
      result <= result_next;
    end
  end

  // Only the split 32-bit form ever waits on two extension slots.
  a_pending_range : assert property (@(posedge clk) disable iff (rst)
    pending_slots != 2'd3)
    else $error("pending slot count out of range");

  a_scaled_one_slot : assert property (@(posedge clk) disable iff (rst)
    !large_unscaled |-> pending_slots != 2'd2)
    else $error("scaled large allocation waits on two slots");

  // An error result leaves the walk blocked with nothing pending.
  a_error_blocks : assert property (@(posedge clk) disable iff (rst)
    (advance && emit && result_next.kind == KIND_ERROR)
      |=> (error_seen && pending_slots == 2'd0))
    else $error("error result did not block the walk");

  // While blocked, no further result is produced.
  a_blocked_silent : assert property (@(posedge clk) disable iff (rst)
    (error_seen && stage_valid && stage.mode != MODE_BEGIN) |-> !emit)
    else $error("result produced after an error");

  // A result is never overwritten while it waits.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !(advance && emit))
    else $error("pending result overwritten");

endmodule : x64_unwind_code_replay_top
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x64 unwind code replay testbench
// Drives begin, code slot and finish items through the replay block and
// checks every result against a predictor of the frame walk, with random
// stalls on both channels, a long output hold-off and an unthrottled tail.
// ----------------------------------------------------------------------------
module testbench;
  import xucr_pkg::*;

  // Longest stretch without any transfer before the run is declared hung.
  // The slowest correct stretch is the output hold-off plus a sender gap.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the deliberate output hold-off that fills the block.
  localparam int HOLD_CYCLES    = 80;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int TOTAL_ITEMS    = 1800;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  x64_unwind_code_replay_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Predicted frame walk state, updated at each accepted item transfer.
  logic [63:0] walk_ptr;
  logic [63:0] frame_base_q;
  logic [1:0]  ext_slots_left;
  logic        ext_unscaled;
  logic [15:0] ext_low_half;
  logic        err_latched;

  result_t expected_results[$];

  int  mismatches     = 0;
  int  live_items     = 0;
  int  restores_seen  = 0;
  int  frames_seen    = 0;
  int  errors_seen    = 0;
  int  stall_cycles   = 0;
  bit  sender_idle    = 1'b0;
  bit  sink_idle      = 1'b0;
  bit  hold_results   = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic result_t make_result(input logic [1:0] kind, input logic [3:0] regnum,
                                          input logic [63:0] addr, input logic [63:0] csp,
                                          input logic [63:0] estab, input logic [1:0] err);
    result_t r;
    r.kind                 = kind;
    r.register_number      = regnum;
    r.address              = addr;
    r.caller_stack_pointer = csp;
    r.establisher_frame    = estab;
    r.error_code           = err;
    return r;
  endfunction

  // Appends one predicted result behind the ones already owed.
  task automatic queue_result(input result_t r);
    expected_results = {expected_results, r};
  endtask

  // An error is reported once; the frame then stays dead until the next begin.
  task automatic flag_error(input err_t code);
    err_latched    = 1'b1;
    ext_slots_left = 2'd0;
    queue_result(make_result(KIND_ERROR, 4'd0, 64'd0, 64'd0, 64'd0, code));
  endtask

  task automatic replay_item(input item_t it);
    logic [3:0] op;
    logic [3:0] info;
    op   = it.slot_value[11:8];
    info = it.slot_value[15:12];
    if (it.mode == MODE_BEGIN) begin
      live_items++;
      if (it.frame_register != 4'd0) begin
        frame_base_q = it.frame_register_value - {56'd0, it.frame_offset, 4'b0000};
      end else begin
        frame_base_q = it.stack_pointer;
      end
      walk_ptr       = frame_base_q;
      ext_slots_left = 2'd0;
      ext_unscaled   = 1'b0;
      ext_low_half   = 16'd0;
      err_latched    = 1'b0;
    end else if (it.mode != MODE_NONE && !err_latched) begin
      live_items++;
      if (it.mode == MODE_FINISH) begin
        if (ext_slots_left != 2'd0) begin
          flag_error(ERR_TRUNCATED);
        end else begin
          queue_result(make_result(KIND_DONE, 4'd0, walk_ptr,
                                   walk_ptr + 64'd8, frame_base_q, ERR_NONE));
        end
      end else if (ext_slots_left != 2'd0) begin
        // Extension slot: all sixteen bits are allocation size.
        if (!ext_unscaled) begin
          walk_ptr       = walk_ptr + {45'd0, it.slot_value, 3'b000};
          ext_slots_left = 2'd0;
        end else if (ext_slots_left == 2'd2) begin
          ext_low_half   = it.slot_value;
          ext_slots_left = 2'd1;
        end else begin
          walk_ptr       = walk_ptr + {32'd0, it.slot_value, ext_low_half};
          ext_slots_left = 2'd0;
        end
      end else begin
        case (op)
          OP_PUSH_NONVOL: begin
            queue_result(make_result(KIND_RESTORE, info, walk_ptr,
                                     64'd0, 64'd0, ERR_NONE));
            walk_ptr = walk_ptr + 64'd8;
          end
          OP_ALLOC_LARGE: begin
            if (info == 4'd0) begin
              ext_slots_left = 2'd1;
              ext_unscaled   = 1'b0;
            end else if (info == 4'd1) begin
              ext_slots_left = 2'd2;
              ext_unscaled   = 1'b1;
            end else begin
              flag_error(ERR_BAD_INFO);
            end
          end
          OP_ALLOC_SMALL: walk_ptr = walk_ptr + {57'd0, info, 3'b000} + 64'd8;
          OP_SET_FPREG: ;
          default: flag_error(ERR_BAD_OP);
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Item sender
  // --------------------------------------------------------------------------
  function automatic item_t random_item();
    item_t it;
    it.mode                 = 2'($urandom);
    it.slot_value           = 16'($urandom);
    it.stack_pointer        = {$urandom, $urandom};
    it.frame_register       = 4'($urandom);
    it.frame_register_value = {$urandom, $urandom};
    it.frame_offset         = 4'($urandom);
    return it;
  endfunction

  // Builds a code slot; the prolog offset byte is unused, so it is random.
  function automatic logic [15:0] unwind_code(input logic [3:0] op, input logic [3:0] info);
    return {info, op, 8'($urandom)};
  endfunction

  // Offers one item and returns at the edge where it is transferred. Valid is
  // left high so the next call can follow back to back.
  task automatic send_item(input item_t it);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    replay_item(it);
  endtask

  task automatic send_begin(input logic [63:0] sp, input logic [3:0] fr,
                            input logic [63:0] frv, input logic [3:0] off);
    item_t it;
    it                      = random_item();
    it.mode                 = MODE_BEGIN;
    it.stack_pointer        = sp;
    it.frame_register       = fr;
    it.frame_register_value = frv;
    it.frame_offset         = off;
    send_item(it);
  endtask

  task automatic send_slot(input logic [15:0] code);
    item_t it;
    it            = random_item();
    it.mode       = MODE_SLOT;
    it.slot_value = code;
    send_item(it);
  endtask

  task automatic send_finish();
    item_t it;
    it      = random_item();
    it.mode = MODE_FINISH;
    send_item(it);
  endtask

  task automatic send_ignored_mode();
    item_t it;
    it      = random_item();
    it.mode = MODE_NONE;
    send_item(it);
  endtask

  // Stops offering items until every predicted result has been checked, then
  // lets the pipeline settle.
  task automatic wait_all_results();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One broken piece dropped into an otherwise well-formed frame.
  task automatic send_broken_piece();
    case ($urandom_range(0, 4))
      0: send_slot(16'($urandom));
      1: send_slot(unwind_code(4'($urandom_range(4, 15)), 4'($urandom)));
      2: send_slot(unwind_code(OP_ALLOC_LARGE, 4'($urandom_range(2, 15))));
      3: begin
        send_slot(unwind_code(OP_ALLOC_LARGE, 4'($urandom_range(0, 1))));
        send_finish();
      end
      default: send_ignored_mode();
    endcase
  endtask

  // A begin, a random prolog of mostly well-formed codes, and one or two finishes.
  task automatic send_random_frame();
    int pick;
    send_begin({$urandom, $urandom}, ($urandom_range(0, 1) != 0) ? 4'($urandom) : 4'd0,
               {$urandom, $urandom}, 4'($urandom));
    repeat ($urandom_range(0, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_slot(unwind_code(OP_PUSH_NONVOL, 4'($urandom)));
      end else if (pick < 55) begin
        send_slot(unwind_code(OP_ALLOC_SMALL, 4'($urandom)));
      end else if (pick < 68) begin
        send_slot(unwind_code(OP_ALLOC_LARGE, 4'd0));
        send_slot(16'($urandom));
      end else if (pick < 82) begin
        send_slot(unwind_code(OP_ALLOC_LARGE, 4'd1));
        send_slot(16'($urandom));
        send_slot(16'($urandom));
      end else if (pick < 94) begin
        send_slot(unwind_code(OP_SET_FPREG, 4'($urandom)));
      end else begin
        send_broken_piece();
      end
    end
    send_finish();
    if ($urandom_range(0, 4) == 0) begin
      send_finish();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes of every field, every op and each special case of the walk.
  task automatic test_directed_cases();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    // Slots and finish straight out of reset walk from a zero frame base.
    send_slot(unwind_code(OP_PUSH_NONVOL, 4'd5));
    send_finish();
    // No frame register: base is the stack pointer, and a push wraps past 2^64.
    send_begin('1, 4'd0, '1, 4'd15);
    send_slot(unwind_code(OP_PUSH_NONVOL, 4'd15));
    send_finish();
    // Frame register with the largest offset below zero wraps downward.
    send_begin('1, 4'd15, 64'd0, 4'd15);
    send_slot(unwind_code(OP_ALLOC_SMALL, 4'd15));
    send_slot(unwind_code(OP_ALLOC_LARGE, 4'd0));
    send_slot(16'hFFFF);
    send_slot(unwind_code(OP_ALLOC_LARGE, 4'd1));
    send_slot(16'hFFFF);
    send_slot(16'hFFFF);
    send_slot(unwind_code(OP_SET_FPREG, 4'd15));
    send_slot(unwind_code(OP_PUSH_NONVOL, 4'd0));
    // A finish leaves the walk alone, so it repeats and the walk goes on.
    send_finish();
    send_finish();
    send_slot(unwind_code(OP_PUSH_NONVOL, 4'd3));
    // Finish with an extension slot still owed is a truncation error, and
    // the dead frame then swallows slots until the next begin.
    send_slot(unwind_code(OP_ALLOC_LARGE, 4'd1));
    send_slot(16'h0000);
    send_finish();
    send_slot(unwind_code(OP_PUSH_NONVOL, 4'd7));
    // Bad large allocation info and an unsupported op.
    send_begin({$urandom, $urandom}, 4'd1, {$urandom, $urandom}, 4'd0);
    send_slot(16'h2100);
    send_begin(64'd0, 4'd0, 64'd0, 4'd0);
    send_slot(16'hFFFF);
    send_ignored_mode();
    wait_all_results();
  endtask

  // The sink holds off for a long stretch while the sender keeps offering
  // pushes back to back, so results pile up and the input stalls.
  task automatic test_output_backpressure();
    sender_idle  = 1'b0;
    hold_results = 1'b1;
    send_begin({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'($urandom));
    repeat (14) send_slot(unwind_code(OP_PUSH_NONVOL, 4'($urandom)));
    send_finish();
    wait_all_results();
  endtask

  // Mostly well-formed frames with random content, some garbage, and idling
  // switched on and off per frame so quiet stretches occur too.
  task automatic test_random_frames();
    while (live_items < RANDOM_ITEMS) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_item(random_item());
      end else begin
        send_random_frame();
      end
      if ($urandom_range(0, 49) == 0) begin
        wait_all_results();
      end
    end
  endtask

  // Full-rate stretch with no idling on either side.
  task automatic test_unthrottled_tail();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    while (live_items < TOTAL_ITEMS) begin
      send_random_frame();
    end
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    walk_ptr       = 64'd0;
    frame_base_q   = 64'd0;
    ext_slots_left = 2'd0;
    ext_unscaled   = 1'b0;
    ext_low_half   = 16'd0;
    err_latched    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_backpressure();
    test_random_frames();
    test_unthrottled_tail();

    wait_all_results();
    repeat (8) @(posedge clk);
    $display("Replayed %0d live items across random frames, garbage and stall patterns.",
             live_items);
    $display("Checked %0d restores, %0d frame results and %0d errors.",
             restores_seen, frames_seen, errors_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, plus the long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int held;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ready <= 1'b0;
      end else if (hold_results) begin
        result_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_results = 1'b0;
        result_ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each result transfer is matched against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with none expected, got %h", $time, result);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(result.kind));
        check_field("register_number", 64'(want.register_number),
                    64'(result.register_number));
        check_field("address", want.address, result.address);
        check_field("caller_stack_pointer", want.caller_stack_pointer,
                    result.caller_stack_pointer);
        check_field("establisher_frame", want.establisher_frame, result.establisher_frame);
        check_field("error_code", 64'(want.error_code), 64'(result.error_code));
        if (want.kind == KIND_RESTORE) begin
          restores_seen++;
        end else if (want.kind == KIND_DONE) begin
          frames_seen++;
        end else begin
          errors_seen++;
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results still owed", $time,
               stall_cycles, expected_results.size());
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
design/xucr_pkg.sv
design/x64_unwind_code_replay_top.sv
dv/testbench.sv
